// ----- rtl/irc_line_tokenizer_unit_assert.svh -----
// Assertion macros shared by the line tokenizer RTL
`ifndef IRC_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define IRC_LINE_TOKENIZER_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define ILT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ILT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- rtl/ilt_pkg.sv -----
// Types, constants and the tokenizer step function of the line tokenizer
package ilt_pkg;

  localparam int unsigned MaxParams = 15;
  localparam logic [3:0]  ParamCap  = (MaxParams < 15) ? 4'(MaxParams) : 4'd15;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [15:0] MaxLineReset = 16'd512;
  localparam logic [15:0] LenSat       = 16'hFFFF;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;

  typedef enum logic [1:0] {
    REG_CMD = 2'd0,
    REG_MID = 2'd1,
    REG_TRL = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    EV_TEXT = 2'd0,
    EV_END  = 2'd1,
    EV_OVF  = 2'd2
  } ev_kind_e;

  // one queue entry: a framed event from the front end
  typedef struct packed {
    ev_kind_e   kind;
    logic       has_cr;
    logic       has_byte;
    logic [7:0] data;
  } ev_t;

  typedef struct packed {
    region_e    region;
    logic       prev_sp;
    logic       in_tok;
    logic [3:0] pcount;
  } tok_st_t;

  typedef struct packed {
    tok_st_t    st;
    logic       emit;
    logic [1:0] kind;
    logic [3:0] pn;
    logic       first;
  } tok_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] pn;
    logic       first;
    logic       msg_end;
    logic       ovf;
    logic       last;
  } out_item_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSp) || (c == ChTab) || (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  // classify one content byte against the current token state
  function automatic tok_res_t tok_step(tok_st_t st, logic [7:0] c);
    tok_res_t r;
    r       = '0;
    r.st    = st;
    r.pn    = st.pcount;
    r.first = !st.in_tok;
    case (st.region)
      REG_CMD: begin
        if (c == ChSp) begin
          r.st.region  = REG_MID;
          r.st.in_tok  = 1'b0;
          r.st.prev_sp = 1'b1;
        end else begin
          r.emit      = 1'b1;
          r.kind      = REG_CMD;
          r.pn        = 4'd0;
          r.st.in_tok = 1'b1;
        end
      end
      REG_MID: begin
        if (st.prev_sp && (c == ChColon)) begin
          r.st.region  = REG_TRL;
          r.st.prev_sp = 1'b0;
          r.st.in_tok  = 1'b0;
        end else if (is_ws(c)) begin
          if (st.in_tok && (st.pcount < ParamCap)) begin
            r.st.pcount = st.pcount + 4'd1;
          end
          r.st.in_tok  = 1'b0;
          r.st.prev_sp = (c == ChSp);
        end else begin
          r.emit       = 1'b1;
          r.kind       = REG_MID;
          r.st.in_tok  = 1'b1;
          r.st.prev_sp = 1'b0;
        end
      end
      default: begin
        r.emit      = 1'b1;
        r.kind      = REG_TRL;
        r.st.in_tok = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ilt_fifo.sv -----
// Short event queue between the framing front end and the tokenizer back end
`include "irc_line_tokenizer_unit_assert.svh"

module ilt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ilt_pkg::ev_t  push_data_i,
  output logic          full_o,
  output logic          head_valid_o,
  output ilt_pkg::ev_t  head_o,
  input  logic          pop_i
);
  import ilt_pkg::*;

  ev_t                mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCw-1:0]  count_q, count_d;
  logic               do_pop;

  assign full_o       = (count_q == FifoCw'(FifoDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ILT_ASSERT_NEVER(a_no_push_full, push_i && full_o, "push into full queue")

endmodule

// ----- rtl/ilt_front.sv -----
// Front end: line length check, overflow, CR holding and LF framing
`include "irc_line_tokenizer_unit_assert.svh"

module ilt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          max_line_bytes_we_i,
  input  logic [15:0]   max_line_bytes_i,
  input  logic          full_i,
  output logic          push_o,
  output ilt_pkg::ev_t  push_data_o
);
  import ilt_pkg::*;

  logic [15:0] max_q;
  logic [15:0] len_q, len_d, len_inc;
  logic        held_q, held_d;
  logic        disc_q, disc_d;
  logic        acc;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i && !full_i;
  assign len_inc    = (len_q != LenSat) ? len_q + 16'd1 : len_q;

  always_comb begin
    len_d       = len_q;
    held_d      = held_q;
    disc_d      = disc_q;
    push_o      = 1'b0;
    push_data_o = '{kind: EV_TEXT, has_cr: held_q, has_byte: 1'b1, data: in_byte_i};
    if (acc && !disc_q) begin
      if (len_inc > max_q) begin
        push_o           = 1'b1;
        push_data_o.kind = EV_OVF;
        disc_d           = 1'b1;
        held_d           = 1'b0;
        len_d            = '0;
      end else if (in_byte_i == ChLf) begin
        push_o           = 1'b1;
        push_data_o.kind = EV_END;
        held_d           = 1'b0;
        len_d            = '0;
      end else if (in_byte_i == ChCr) begin
        // a second CR releases the one already held
        push_o               = held_q;
        push_data_o.has_byte = 1'b0;
        held_d               = 1'b1;
        len_d                = len_inc;
      end else begin
        push_o = 1'b1;
        held_d = 1'b0;
        len_d  = len_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MaxLineReset;
      len_q  <= '0;
      held_q <= 1'b0;
      disc_q <= 1'b0;
    end else begin
      if (max_line_bytes_we_i) begin
        max_q <= max_line_bytes_i;
      end
      len_q  <= len_d;
      held_q <= held_d;
      disc_q <= disc_d;
    end
  end

  `ILT_ASSERT(a_disc_sticky, disc_q |=> disc_q, "disconnect flag cleared")

endmodule

// ----- rtl/ilt_back.sv -----
// Back end: token classification and the registered result stage
`include "irc_line_tokenizer_unit_assert.svh"

module ilt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ilt_pkg::ev_t      head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ilt_pkg::out_item_t out_o
);
  import ilt_pkg::*;

  tok_st_t   st_q, st_d;
  logic      phase_q, phase_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, item;
  logic      load;
  logic      act;
  tok_res_t  res_cr, res_after_cr, res_byte;

  assign act         = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign res_cr       = tok_step(st_q, ChCr);
  assign res_after_cr = tok_step(res_cr.st, head_i.data);
  assign res_byte     = tok_step(st_q, head_i.data);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    item        = '0;
    item.last   = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    if (act) begin
      unique case (head_i.kind)
        EV_END: begin
          load         = 1'b1;
          item.msg_end = 1'b1;
          st_d         = '0;
          phase_d      = 1'b0;
          pop_o        = 1'b1;
        end
        EV_OVF: begin
          load     = 1'b1;
          item.ovf = 1'b1;
          st_d     = '0;
          phase_d  = 1'b0;
          pop_o    = 1'b1;
        end
        EV_TEXT: begin
          if (head_i.has_cr && !phase_q) begin
            if (res_cr.emit && head_i.has_byte && res_after_cr.emit) begin
              // both produce a result: the CR goes out first and the byte follows from the same queue entry
              load       = 1'b1;
              item.data  = ChCr;
              item.kind  = res_cr.kind;
              item.pn    = res_cr.pn;
              item.first = res_cr.first;
              item.last  = 1'b0;
              st_d       = res_cr.st;
              phase_d    = 1'b1;
            end else begin
              st_d  = head_i.has_byte ? res_after_cr.st : res_cr.st;
              pop_o = 1'b1;
              if (res_cr.emit) begin
                load       = 1'b1;
                item.data  = ChCr;
                item.kind  = res_cr.kind;
                item.pn    = res_cr.pn;
                item.first = res_cr.first;
              end else if (head_i.has_byte && res_after_cr.emit) begin
                load       = 1'b1;
                item.data  = head_i.data;
                item.kind  = res_after_cr.kind;
                item.pn    = res_after_cr.pn;
                item.first = res_after_cr.first;
              end
            end
          end else begin
            st_d    = res_byte.st;
            phase_d = 1'b0;
            pop_o   = 1'b1;
            if (res_byte.emit) begin
              load       = 1'b1;
              item.data  = head_i.data;
              item.kind  = res_byte.kind;
              item.pn    = res_byte.pn;
              item.first = res_byte.first;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  `ILT_ASSERT(a_phase_head, phase_q |-> (head_valid_i && head_i.has_byte), "split without byte")
  `ILT_ASSERT(a_split_not_last, $rose(phase_q) |-> (out_valid_q && !out_q.last), "CR marked last")

endmodule

// ----- rtl/irc_line_tokenizer_unit.sv -----
// Top level of the line tokenizer: front end, event queue and back end
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | in        | in_valid_i / in_stall_o  | in_byte_i
//  out      | out       | out_valid_o / out_stall_i| out_byte_o, token_kind_o, ...
//  cfg      | in        | max_line_bytes_we_i      | max_line_bytes_i
//
// One byte per cycle is taken while in_stall_o is low; the result is registered.
// A released CR and the following byte that both give a result leave from one queue
// entry in turn; the four-entry event queue absorbs that and output stalls.
// Reset is asynchronous; the line limit comes up at 512.
// in_stall_o rises only when the event queue is full.
`include "irc_line_tokenizer_unit_assert.svh"

module irc_line_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        max_line_bytes_we_i,
  input  logic [15:0] max_line_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  token_kind_o,
  output logic [3:0]  param_number_o,
  output logic        token_first_o,
  output logic        message_end_o,
  output logic        overflow_o,
  output logic        last_of_run_o
);
  import ilt_pkg::*;

  logic      push, full, head_valid, pop;
  ev_t       push_data, head;
  out_item_t out_item;

  ilt_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .max_line_bytes_we_i,
    .max_line_bytes_i,
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ilt_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  ilt_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .out_o        (out_item)
  );

  assign out_byte_o     = out_item.data;
  assign token_kind_o   = out_item.kind;
  assign param_number_o = out_item.pn;
  assign token_first_o  = out_item.first;
  assign message_end_o  = out_item.msg_end;
  assign overflow_o     = out_item.ovf;
  assign last_of_run_o  = out_item.last;

endmodule

// ----- tb/irc_line_tokenizer_unit_tb.sv -----
// Self-checking testbench for the line tokenizer: framed IRC lines and noise against a predictor
module irc_line_tokenizer_unit_tb;
  import ilt_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int Settle     = 8;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] pnum;
    logic       tok_first;
    logic       msg_end;
    logic       ovf;
    logic       last;
  } token_t;

  class token_predictor;
    token_t      due_tokens[$];
    int          errors;
    int          results_seen;
    int          lines_seen;
    int          ovf_seen;
    logic [15:0] line_limit;
    region_e     region;
    bit          held_cr;
    bit          prev_sp;
    bit          in_tok;
    bit          disc;
    logic [3:0]  pcount;
    logic [15:0] line_len;

    function new();
      errors       = 0;
      results_seen = 0;
      lines_seen   = 0;
      ovf_seen     = 0;
      line_limit   = MaxLineReset;
      disc         = 1'b0;
      clear_line();
    endfunction

    function void clear_line();
      region   = REG_CMD;
      held_cr  = 1'b0;
      prev_sp  = 1'b0;
      in_tok   = 1'b0;
      pcount   = 4'd0;
      line_len = 16'd0;
    endfunction

    function void set_limit(logic [15:0] v);
      line_limit = v;
    endfunction

    function void push_token(logic [7:0] d, logic [1:0] k, logic [3:0] p, bit f, bit e, bit o);
      token_t t;
      t.data      = d;
      t.kind      = k;
      t.pnum      = p;
      t.tok_first = f;
      t.msg_end   = e;
      t.ovf       = o;
      t.last      = 1'b0;
      due_tokens.insert(due_tokens.size(), t);
    endfunction

    // tag one content byte of the current line
    function void tag_byte(logic [7:0] c);
      bit starts;
      starts = !in_tok;
      case (region)
        REG_CMD: begin
          if (c == ChSp) begin
            region  = REG_MID;
            in_tok  = 1'b0;
            prev_sp = 1'b1;
          end else begin
            in_tok = 1'b1;
            push_token(c, REG_CMD, 4'd0, starts, 1'b0, 1'b0);
          end
        end
        REG_MID: begin
          if (prev_sp && c == ChColon) begin
            region  = REG_TRL;
            prev_sp = 1'b0;
            in_tok  = 1'b0;
          end else if (c == ChSp || c == ChTab || c == ChVt || c == ChFf || c == ChCr) begin
            if (in_tok && pcount < ParamCap) pcount++;
            in_tok  = 1'b0;
            prev_sp = (c == ChSp);
          end else begin
            in_tok  = 1'b1;
            prev_sp = 1'b0;
            push_token(c, REG_MID, pcount, starts, 1'b0, 1'b0);
          end
        end
        default: begin
          in_tok = 1'b1;
          push_token(c, REG_TRL, pcount, starts, 1'b0, 1'b0);
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] c);
      int mark;
      mark = due_tokens.size();
      if (disc) return;
      if (line_len != LenSat) line_len++;
      if (line_len > line_limit) begin
        disc = 1'b1;
        clear_line();
        push_token(8'd0, REG_CMD, 4'd0, 1'b0, 1'b0, 1'b1);
      end else if (c == ChLf) begin
        push_token(8'd0, REG_CMD, 4'd0, 1'b0, 1'b1, 1'b0);
        clear_line();
      end else begin
        if (held_cr) begin
          held_cr = 1'b0;
          tag_byte(ChCr);
        end
        if (c == ChCr) held_cr = 1'b1;
        else tag_byte(c);
      end
      if (due_tokens.size() > mark) due_tokens[due_tokens.size() - 1].last = 1'b1;
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= 30) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task match_token(token_t got);
      token_t exp;
      results_seen++;
      if (got.msg_end === 1'b1) lines_seen++;
      if (got.ovf === 1'b1) ovf_seen++;
      if (due_tokens.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer, out_byte %h", got.data));
      end else begin
        exp = due_tokens.pop_front();
        if (got.data !== exp.data)
          flag_mismatch($sformatf("out_byte %h, expected %h", got.data, exp.data));
        if (got.kind !== exp.kind)
          flag_mismatch($sformatf("token_kind %0d, expected %0d", got.kind, exp.kind));
        if (got.pnum !== exp.pnum)
          flag_mismatch($sformatf("param_number %0d, expected %0d", got.pnum, exp.pnum));
        if (got.tok_first !== exp.tok_first)
          flag_mismatch($sformatf("token_first %b, expected %b", got.tok_first, exp.tok_first));
        if (got.msg_end !== exp.msg_end)
          flag_mismatch($sformatf("message_end %b, expected %b", got.msg_end, exp.msg_end));
        if (got.ovf !== exp.ovf)
          flag_mismatch($sformatf("overflow %b, expected %b", got.ovf, exp.ovf));
        if (got.last !== exp.last)
          flag_mismatch($sformatf("last_of_run %b, expected %b", got.last, exp.last));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'd0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_limit = 16'd0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  token_kind;
  logic [3:0]  param_number;
  logic        token_first;
  logic        message_end;
  logic        overflow;
  logic        last_of_run;

  token_predictor tracker;
  int             sent  = 0;
  int             quiet = 0;
  bit             calm  = 1'b0;

  irc_line_tokenizer_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_byte_i           (in_byte),
    .max_line_bytes_we_i (cfg_we),
    .max_line_bytes_i    (cfg_limit),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_byte_o          (out_byte),
    .token_kind_o        (token_kind),
    .param_number_o      (param_number),
    .token_first_o       (token_first),
    .message_end_o       (message_end),
    .overflow_o          (overflow),
    .last_of_run_o       (last_of_run)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    token_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.data      = out_byte;
      got.kind      = token_kind;
      got.pnum      = param_number;
      got.tok_first = token_first;
      got.msg_end   = message_end;
      got.ovf       = overflow;
      got.last      = last_of_run;
      tracker.match_token(got);
    end
    out_stall <= !calm && ($urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", QuietLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    calm = (sent >= 120 && sent < 260);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    tracker.take_byte(b);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChLf || b == ChCr || b == ChSp || b == ChTab || b == ChVt || b == ChFf);
    return b;
  endfunction

  // command, middle parameters, optional trailing, CR LF or bare LF
  task automatic send_message();
    int n_cmd;
    int n_par;
    int n_len;
    n_cmd = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
    repeat (n_cmd) send_byte(word_byte());
    n_par = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
    for (int i = 0; i < n_par; i++) begin
      send_byte(ChSp);
      case ($urandom_range(5))
        0: send_byte(ChSp);
        1: send_byte(ChTab);
        2: send_byte(ChCr);
        default: ;
      endcase
      n_len = (n_par > 8) ? 1 : $urandom_range(1, 6);
      repeat (n_len) send_byte(word_byte());
    end
    if ($urandom_range(1)) begin
      send_byte(ChSp);
      send_byte(ChColon);
      repeat ($urandom_range(0, 10)) begin
        logic [7:0] t;
        do t = 8'($urandom_range(255)); while (t == ChLf);
        send_byte(t);
      end
    end
    if ($urandom_range(9) < 7) send_byte(ChCr);
    send_byte(ChLf);
  endtask

  task automatic send_noise(int n_body);
    repeat (n_body) send_byte(8'($urandom_range(255)));
    send_byte(ChLf);
  endtask

  // let the block drain before touching the limit
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_tokens.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_limit <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.set_limit(v);
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_byte(ChLf);
    send_text("A\015B x :\015\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChSp);
    send_byte(8'hFF);
    send_byte(ChTab);
    send_byte(ChCr);
    send_byte("z");
    send_byte(ChVt);
    send_byte(ChFf);
    send_text("q :t :\n");

    write_limit(16'hFFFF);
    while (sent < 300) begin
      if ($urandom_range(3) != 0) send_message();
      else send_noise($urandom_range(0, 40));
    end

    write_limit(16'd1);
    repeat (6) send_byte(ChLf);

    write_limit(16'd24);
    send_noise(23);
    while (sent < 380) send_noise($urandom_range(0, 23));

    write_limit(16'd200);
    while (sent < 680) begin
      if ($urandom_range(4) != 0) send_message();
      else send_noise($urandom_range(0, 60));
    end

    // over-long line: overflow, then everything is ignored
    write_limit(16'd16);
    repeat (17) send_byte(word_byte());
    repeat (5) send_byte(8'($urandom_range(255)));
    settle();

    $display("%0d bytes sent, %0d results checked: %0d lines, %0d overflow", sent,
             tracker.results_seen, tracker.lines_seen, tracker.ovf_seen);
    $display("line limits 512, 65535, 1, 24, 200 and 16; %0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
